// ===== hdl/lsfb_pkg.sv =====
// Shared types and constants for the LED strip frame buffer serializer.
`timescale 1ns / 1ps

package lsfb_pkg;

  localparam int unsigned LED_COUNT    = 128;
  localparam int unsigned LED_AW       = $clog2(LED_COUNT);
  localparam int unsigned LED_CW       = LED_AW + 1;
  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned BIT_CW       = 5;
  localparam int unsigned TICK_W       = 16;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned WORD_W       = 3 * COLOR_W;
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned IN_DATA_W    = 48;
  localparam int unsigned OUT_DATA_W   = 8;

  localparam logic [7:0]  RST_ZERO_HIGH  = 8'd8;
  localparam logic [7:0]  RST_ONE_HIGH   = 8'd16;
  localparam logic [7:0]  RST_PERIOD     = 8'd25;
  localparam logic [15:0] RST_RESET_LOW  = 16'd200;
  localparam logic [7:0]  RST_ACTIVE     = 8'd10;

  typedef enum logic [FUNC_W-1:0] {
    FN_FILL    = 3'd0,
    FN_ROT_R   = 3'd1,
    FN_ROT_L   = 3'd2,
    FN_BLANK   = 3'd3,
    FN_RESTORE = 3'd4,
    FN_SHOW    = 3'd5,
    FN_TICK    = 3'd6
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH = 3'd0,
    CFG_ONE_HIGH  = 3'd1,
    CFG_PERIOD    = 3'd2,
    CFG_RESET_LOW = 3'd3,
    CFG_ACTIVE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_BITS  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_WALK_FIN,
    ST_TICK_RD,
    ST_TICK_EX
  } ctrl_state_e;

  typedef struct packed {
    logic  load;
    func_e op;
    logic  fill_step;
    logic  walk_rd;
    logic  walk_wr;
    logic  walk_fin;
    logic  show;
    logic  tick_rd;
    logic  tick_ex;
  } lsfb_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic fill_done;
    logic walk_end;
    logic out_free;
  } lsfb_status_t;

endpackage

// ===== hdl/lsfb_ctrl.sv =====
// Command sequencer for the frame store and the line serializer.
`timescale 1ns / 1ps

module lsfb_ctrl
  import lsfb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  func_e        in_func_i,
  input  lsfb_status_t status_i,
  output lsfb_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  func_e       op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= FN_FILL;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = in_func_i;
          case (in_func_i)
            FN_FILL: state_d = ST_FILL;
            FN_ROT_R, FN_ROT_L, FN_BLANK, FN_RESTORE: begin
              if (status_i.range_ok) state_d = ST_WALK_RD;
            end
            FN_SHOW: cmd_o.show = 1'b1;
            FN_TICK: state_d = ST_TICK_RD;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (status_i.fill_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      ST_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        cmd_o.walk_wr = 1'b1;
        if (status_i.walk_end) begin
          if (op_q == FN_ROT_R || op_q == FN_ROT_L) begin
            state_d = ST_WALK_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_FIN: begin
        cmd_o.walk_fin = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_TICK_RD: begin
        cmd_o.tick_rd = 1'b1;
        state_d       = ST_TICK_EX;
      end
      ST_TICK_EX: begin
        cmd_o.tick_rd = 1'b1;
        if (status_i.out_free) begin
          cmd_o.tick_ex = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_tick_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_ex |-> status_i.out_free)
    else $error("tick result issued while output slot busy");

  a_fill_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fill_step |-> !status_i.fill_done)
    else $error("fill write issued past its run");

  a_fin_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.walk_fin |-> ($past(state_q) == ST_WALK_WR && $past(status_i.walk_end)))
    else $error("rotate wrap-around write without finished walk");
`endif

endmodule

// ===== hdl/lsfb_datapath.sv =====
// Frame and shadow stores, range walker, line timing counters and output register.
`timescale 1ns / 1ps

module lsfb_datapath
  import lsfb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lsfb_cmd_t              cmd_i,
  output lsfb_status_t           status_o,
  input  func_e                  in_func_i,
  input  logic [LED_AW-1:0]      in_first_i,
  input  logic [LED_AW-1:0]      in_last_i,
  input  logic [7:0]             in_count_i,
  input  logic [WORD_W-1:0]      in_color_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_level_o,
  output logic                   out_sending_o,
  output logic                   out_done_o
);

  // Configuration registers
  logic [7:0]  zero_high_q, one_high_q, period_q, active_q;
  logic [15:0] reset_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= RST_ZERO_HIGH;
      one_high_q  <= RST_ONE_HIGH;
      period_q    <= RST_PERIOD;
      reset_low_q <= RST_RESET_LOW;
      active_q    <= RST_ACTIVE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ZERO_HIGH: zero_high_q <= cfg_data_i[7:0];
        CFG_ONE_HIGH:  one_high_q  <= cfg_data_i[7:0];
        CFG_PERIOD:    period_q    <= cfg_data_i[7:0];
        CFG_RESET_LOW: reset_low_q <= cfg_data_i;
        CFG_ACTIVE:    active_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [LED_CW-1:0] frame_len;
  always_comb begin
    if (active_q == '0) begin
      frame_len = LED_CW'(1);
    end else if (LED_CW'(active_q) > LED_CW'(LED_COUNT)) begin
      frame_len = LED_CW'(LED_COUNT);
    end else begin
      frame_len = LED_CW'(active_q);
    end
  end

  // Stores
  logic [WORD_W-1:0] fs_mem [LED_COUNT];
  logic [WORD_W-1:0] sh_mem [LED_COUNT];
  logic [LED_COUNT-1:0] fs_vld_q;
  logic              fs_rvld_q;
  logic [WORD_W-1:0] fs_rdata_q, sh_rdata_q, fs_word;
  logic              fs_we, sh_we;
  logic [LED_AW-1:0] fs_waddr, fs_raddr;
  logic [WORD_W-1:0] fs_wdata;

  // Walker and fill registers
  logic [LED_AW-1:0] p_q, end_q, start_q;
  logic              up_q, have_q;
  logic [WORD_W-1:0] carry_q, color_q;
  logic [LED_CW-1:0] fill_addr_q;
  logic [7:0]        fill_rem_q;

  // Serializer registers
  phase_e             phase_q;
  logic [LED_AW-1:0]  led_q;
  logic [BIT_CW-1:0]  bit_q;
  logic [TICK_W-1:0]  tick_q;
  logic               out_valid_q, out_level_q, out_sending_q, out_done_q;

  assign fs_word  = fs_rvld_q ? fs_rdata_q : '0;
  assign fs_raddr = cmd_i.tick_rd ? led_q : p_q;

  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = p_q;
    fs_wdata = carry_q;
    sh_we    = 1'b0;
    if (cmd_i.fill_step) begin
      fs_we    = 1'b1;
      fs_waddr = fill_addr_q[LED_AW-1:0];
      fs_wdata = color_q;
    end else if (cmd_i.walk_fin) begin
      fs_we    = 1'b1;
      fs_waddr = start_q;
    end else if (cmd_i.walk_wr) begin
      case (cmd_i.op)
        FN_ROT_R, FN_ROT_L: fs_we = have_q;
        FN_BLANK: begin
          fs_we    = 1'b1;
          fs_wdata = '0;
          sh_we    = 1'b1;
        end
        FN_RESTORE: begin
          fs_we    = 1'b1;
          fs_wdata = sh_rdata_q;
        end
        default: fs_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    fs_rdata_q <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sh_we) sh_mem[p_q] <= fs_word;
    if (cmd_i.walk_rd) sh_rdata_q <= sh_mem[p_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_vld_q  <= '0;
      fs_rvld_q <= 1'b0;
    end else begin
      if (fs_we) fs_vld_q[fs_waddr] <= 1'b1;
      fs_rvld_q <= fs_vld_q[fs_raddr];
    end
  end

  // Walker and fill control
  logic load_up;
  assign load_up = (in_func_i != FN_ROT_L);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= '0;
      end_q       <= '0;
      start_q     <= '0;
      up_q        <= 1'b1;
      have_q      <= 1'b0;
      fill_addr_q <= '0;
      fill_rem_q  <= '0;
    end else if (cmd_i.load) begin
      up_q        <= load_up;
      p_q         <= load_up ? in_first_i : in_last_i;
      start_q     <= load_up ? in_first_i : in_last_i;
      end_q       <= load_up ? in_last_i : in_first_i;
      have_q      <= 1'b0;
      fill_addr_q <= {1'b0, in_first_i};
      fill_rem_q  <= in_count_i;
    end else if (cmd_i.fill_step) begin
      fill_addr_q <= fill_addr_q + 1'b1;
      fill_rem_q  <= fill_rem_q - 1'b1;
    end else if (cmd_i.walk_wr) begin
      have_q <= 1'b1;
      if (p_q != end_q) p_q <= up_q ? p_q + 1'b1 : p_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) color_q <= in_color_i;
    if (cmd_i.walk_wr) carry_q <= fs_word;
  end

  // Serializer
  logic               cur_bit, level;
  logic [BIT_CW-1:0]  bit_sel, bit_inc;
  logic [7:0]         high;
  logic [TICK_W-1:0]  tick_inc;
  logic [LED_CW-1:0]  led_inc;
  phase_e             phase_d;
  logic [LED_AW-1:0]  led_d;
  logic [BIT_CW-1:0]  bit_d;
  logic [TICK_W-1:0]  tick_d;
  logic               sending, done;

  always_comb begin
    bit_sel  = BIT_CW'(BITS_PER_LED - 1) - bit_q;
    cur_bit  = fs_word[bit_sel];
    high     = cur_bit ? one_high_q : zero_high_q;
    tick_inc = tick_q + 1'b1;
    bit_inc  = bit_q + 1'b1;
    led_inc  = {1'b0, led_q} + 1'b1;
    phase_d  = phase_q;
    led_d    = led_q;
    bit_d    = bit_q;
    tick_d   = tick_q;
    level    = 1'b0;
    sending  = 1'b0;
    done     = 1'b0;
    case (phase_q)
      PH_RESET: begin
        sending = 1'b1;
        if (tick_inc >= reset_low_q || tick_inc == '0) begin
          tick_d  = '0;
          led_d   = '0;
          bit_d   = '0;
          phase_d = PH_BITS;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_BITS: begin
        sending = 1'b1;
        level   = (tick_q < TICK_W'(high));
        if (tick_inc >= TICK_W'(period_q)) begin
          tick_d = '0;
          if (bit_inc >= BIT_CW'(BITS_PER_LED)) begin
            bit_d = '0;
            if (led_inc >= frame_len) begin
              led_d   = '0;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              led_d = led_inc[LED_AW-1:0];
            end
          end else begin
            bit_d = bit_inc;
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      led_q   <= '0;
      bit_q   <= '0;
      tick_q  <= '0;
    end else if (cmd_i.show) begin
      phase_q <= PH_RESET;
      led_q   <= '0;
      bit_q   <= '0;
      tick_q  <= '0;
    end else if (cmd_i.tick_ex) begin
      phase_q <= phase_d;
      led_q   <= led_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tick_ex) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_ex) begin
      out_level_q   <= level;
      out_sending_q <= sending;
      out_done_q    <= done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_level_o   = out_level_q;
  assign out_sending_o = out_sending_q;
  assign out_done_o    = out_done_q;

  assign status_o.range_ok  = (in_first_i <= in_last_i) &&
                              (LED_CW'(in_last_i) < LED_CW'(LED_COUNT));
  assign status_o.fill_done = (fill_rem_q == '0) || (fill_addr_q >= LED_CW'(LED_COUNT));
  assign status_o.walk_end  = (p_q == end_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_bit_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q < BIT_CW'(BITS_PER_LED))
    else $error("bit counter left the color word");

  a_cell_tick_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BITS |-> tick_q[TICK_W-1:8] == '0)
    else $error("bit cell tick count beyond period range");

  a_done_while_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_sending_q)
    else $error("frame end flagged outside a frame");
`endif

endmodule

// ===== hdl/led_strip_frame_buffer_serializer.sv =====
// Top level of the LED strip frame buffer serializer.
`timescale 1ns / 1ps

// Usage:
//  s_axis carries commands: tuser selects fill, rotate right/left, blank, restore,
//  show or tick; tdata carries the range, fill count and fill color.
//  Only tick transactions produce a result on m_axis: tdata bit 0 is the line
//  level for that tick, bit 1 is high while a frame is in flight, tlast marks the
//  tick that ends the frame.
//  cfg writes the timing and frame length registers; write only while idle.
//  Steps: a tick is accepted, then reads the frame store entry, then computes
//  the cell level into the output register. Fill writes its entries one by
//  one. Rotate, blank and restore walk the range through the frame store, a
//  read and a write per entry, with one more write for rotate; a bad range
//  is accepted and ignored.
//  Reset: frame store reads as all zero, serializer idle, registers at defaults.
//  A stalled m_axis holds the result; the next command is still taken, and a
//  following tick waits in its last step until the output register frees.

module led_strip_frame_buffer_serializer
  import lsfb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // first_index[6:0], last_index[13:7], fill_count[21:14], red[29:22],
  // green[37:30], blue[45:38], zero[47:46]
  input  logic [IN_DATA_W-1:0]   s_axis_tdata_i,
  // func[2:0]
  input  logic [FUNC_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // line_level[0], sending[1], zero[7:2]
  output logic [OUT_DATA_W-1:0]  m_axis_tdata_o,
  // frame_done
  output logic                   m_axis_tlast_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  lsfb_cmd_t    cmd;
  lsfb_status_t status;
  func_e        in_func;
  logic         level, sending;

  assign in_func     = func_e'(s_axis_tuser_i);
  assign cfg_ready_o = 1'b1;

  lsfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_func_i  (in_func),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsfb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_func_i     (in_func),
    .in_first_i    (s_axis_tdata_i[6:0]),
    .in_last_i     (s_axis_tdata_i[13:7]),
    .in_count_i    (s_axis_tdata_i[21:14]),
    .in_color_i    ({s_axis_tdata_i[37:30], s_axis_tdata_i[29:22], s_axis_tdata_i[45:38]}),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_level_o   (level),
    .out_sending_o (sending),
    .out_done_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b0, sending, level};

endmodule

// ===== bench/tb_led_strip_frame_buffer_serializer.sv =====
// Self-checking testbench for the LED strip frame buffer serializer with a tick-level predictor.
`timescale 1ns / 1ps

module tb_led_strip_frame_buffer_serializer;
  import lsfb_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [LED_AW-1:0]  first_idx;
    logic [LED_AW-1:0]  last_idx;
    logic [7:0]         count;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } strip_cmd_t;

  typedef struct packed {
    logic level;
    logic sending;
    logic done;
  } tick_out_t;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [FUNC_W-1:0]     s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  led_strip_frame_buffer_serializer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  logic [WORD_W-1:0] frame_mem  [LED_COUNT];
  logic [WORD_W-1:0] shadow_mem [LED_COUNT];
  logic [7:0]        led_cnt;
  logic [BIT_CW-1:0] bit_cnt;
  logic [TICK_W-1:0] tick_cnt;
  phase_e            phase;
  logic [7:0]        zero_hi;
  logic [7:0]        one_hi;
  logic [7:0]        period;
  logic [15:0]       reset_low;
  logic [7:0]        active;

  strip_cmd_t  pending_cmds [$];
  tick_out_t   expected_ticks [$];
  strip_cmd_t  cur_cmd;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  bit          send_burst  = 1'b0;
  bit          recv_burst  = 1'b0;
  int unsigned errors      = 0;
  tick_out_t   got;
  tick_out_t   want;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("tb_led_strip_frame_buffer_serializer failed");
    $finish;
  end

  task automatic reset_model();
    for (int i = 0; i < LED_COUNT; i++) begin
      frame_mem[i]  = '0;
      shadow_mem[i] = '0;
    end
    led_cnt   = '0;
    bit_cnt   = '0;
    tick_cnt  = '0;
    phase     = PH_IDLE;
    zero_hi   = RST_ZERO_HIGH;
    one_hi    = RST_ONE_HIGH;
    period    = RST_PERIOD;
    reset_low = RST_RESET_LOW;
    active    = RST_ACTIVE;
  endtask

  function automatic int unsigned frame_len();
    if (active == 0) return 1;
    if (active > LED_COUNT) return LED_COUNT;
    return 32'(active);
  endfunction

  task automatic apply_cmd(input strip_cmd_t c);
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] keep;
    logic              ok;
    logic              bitv;
    logic [7:0]        high;
    int                idx;
    tick_out_t         r;
    word = {c.green, c.red, c.blue};
    ok   = (c.first_idx <= c.last_idx);
    r    = '0;
    case (c.func)
      FN_FILL: begin
        for (int i = 0; i < c.count; i++) begin
          idx = c.first_idx + i;
          if (idx < LED_COUNT) frame_mem[idx] = word;
        end
      end
      FN_ROT_R: if (ok) begin
        keep = frame_mem[c.last_idx];
        for (int i = c.last_idx; i > c.first_idx; i--) frame_mem[i] = frame_mem[i-1];
        frame_mem[c.first_idx] = keep;
      end
      FN_ROT_L: if (ok) begin
        keep = frame_mem[c.first_idx];
        for (int i = c.first_idx; i < c.last_idx; i++) frame_mem[i] = frame_mem[i+1];
        frame_mem[c.last_idx] = keep;
      end
      FN_BLANK: if (ok) begin
        for (int i = c.first_idx; i <= c.last_idx; i++) begin
          shadow_mem[i] = frame_mem[i];
          frame_mem[i]  = '0;
        end
      end
      FN_RESTORE: if (ok) begin
        for (int i = c.first_idx; i <= c.last_idx; i++) frame_mem[i] = shadow_mem[i];
      end
      FN_SHOW: begin
        phase    = PH_RESET;
        tick_cnt = '0;
        led_cnt  = '0;
        bit_cnt  = '0;
      end
      FN_TICK: begin
        if (phase == PH_RESET) begin
          r.sending = 1'b1;
          tick_cnt  = tick_cnt + 1'b1;
          if (tick_cnt >= reset_low || tick_cnt == 0) begin
            tick_cnt = '0;
            led_cnt  = '0;
            bit_cnt  = '0;
            phase    = PH_BITS;
          end
        end else if (phase == PH_BITS) begin
          idx       = (led_cnt < LED_COUNT) ? int'(led_cnt) : 0;
          bitv      = frame_mem[idx][BITS_PER_LED - 1 - bit_cnt];
          high      = bitv ? one_hi : zero_hi;
          r.sending = 1'b1;
          r.level   = (tick_cnt < high);
          tick_cnt  = tick_cnt + 1'b1;
          if (tick_cnt >= period) begin
            tick_cnt = '0;
            bit_cnt  = bit_cnt + 1'b1;
            if (bit_cnt >= BITS_PER_LED) begin
              bit_cnt = '0;
              led_cnt = led_cnt + 1'b1;
              if (led_cnt >= frame_len()) begin
                led_cnt = '0;
                phase   = PH_IDLE;
                r.done  = 1'b1;
              end
            end
          end
        end
        expected_ticks.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned idle_len(input bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // drive commands, predict on each accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) apply_cmd(cur_cmd);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          s_axis_tdata_i <= {2'b00, cur_cmd.blue, cur_cmd.green, cur_cmd.red,
                             cur_cmd.count, cur_cmd.last_idx, cur_cmd.first_idx};
          s_axis_tuser_i  <= cur_cmd.func;
          s_axis_tvalid_i <= 1'b1;
          if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
          send_gap = idle_len(send_burst);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // check results, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{m_axis_tdata_o[0], m_axis_tdata_o[1], m_axis_tlast_o};
        if (expected_ticks.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual level %0b sending %0b frame_done %0b",
                   $time, got.level, got.sending, got.done);
        end else begin
          want = expected_ticks.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: tick mismatch, expected level %0b sending %0b frame_done %0b, %s",
                     $time, want.level, want.sending, want.done,
                     $sformatf("actual level %0b sending %0b frame_done %0b",
                               got.level, got.sending, got.done));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 99) == 0) recv_burst = !recv_burst;
        stall_left = ($urandom_range(0, 99) < 20) ? idle_len(recv_burst) : 0;
      end
    end
  end

  function automatic strip_cmd_t make_cmd(input logic [FUNC_W-1:0] func,
                                          input int first, input int last, input int count,
                                          input int red, input int green, input int blue);
    strip_cmd_t c;
    c.func      = func;
    c.first_idx = LED_AW'(first);
    c.last_idx  = LED_AW'(last);
    c.count     = 8'(count);
    c.red       = COLOR_W'(red);
    c.green     = COLOR_W'(green);
    c.blue      = COLOR_W'(blue);
    return c;
  endfunction

  function automatic strip_cmd_t rand_raw();
    strip_cmd_t c;
    c.func      = FUNC_W'($urandom_range(FN_FILL, FN_UNUSED));
    c.first_idx = LED_AW'($urandom());
    c.last_idx  = LED_AW'($urandom());
    c.count     = 8'($urandom());
    c.red       = COLOR_W'($urandom());
    c.green     = COLOR_W'($urandom());
    c.blue      = COLOR_W'($urandom());
    return c;
  endfunction

  function automatic strip_cmd_t rand_edit();
    strip_cmd_t c;
    int         t;
    c      = rand_raw();
    c.func = FUNC_W'($urandom_range(FN_FILL, FN_RESTORE));
    if ($urandom_range(0, 1)) c.first_idx = LED_AW'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0, 1: begin
        t = int'(c.first_idx) + int'($urandom_range(0, 7));
        c.last_idx = (t > LED_COUNT - 1) ? LED_AW'(LED_COUNT - 1) : LED_AW'(t);
      end
      2: c.last_idx = LED_AW'(LED_COUNT - 1);
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: c.count = 8'($urandom_range(1, 8));
      1: c.count = 8'(LED_COUNT);
      default: ;
    endcase
    return c;
  endfunction

  function automatic strip_cmd_t rand_with(input logic [FUNC_W-1:0] func);
    strip_cmd_t c;
    c      = rand_raw();
    c.func = func;
    return c;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || s_axis_tvalid_i || expected_ticks.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_ZERO_HIGH: zero_hi   = data[7:0];
      CFG_ONE_HIGH:  one_hi    = data[7:0];
      CFG_PERIOD:    period    = data[7:0];
      CFG_RESET_LOW: reset_low = data;
      CFG_ACTIVE:    active    = data[7:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input int z, input int o, input int p, input int rl, input int al,
                           input int budget);
    int made;
    int n;
    int ft;
    strip_cmd_t c;
    wait_idle();
    cfg_write(CFG_ZERO_HIGH, CFG_DATA_W'(z));
    cfg_write(CFG_ONE_HIGH, CFG_DATA_W'(o));
    cfg_write(CFG_PERIOD, CFG_DATA_W'(p));
    cfg_write(CFG_RESET_LOW, CFG_DATA_W'(rl));
    cfg_write(CFG_ACTIVE, CFG_DATA_W'(al));
    cfg_valid_i <= 1'b0;
    ft = ((rl == 0) ? 1 : rl) + frame_len() * BITS_PER_LED * ((p == 0) ? 1 : p);
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 99) < 80) begin
        pending_cmds.push_back(rand_with(FN_SHOW));
        made++;
        n = ft + $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, ft);
        if (n > budget - made) n = (budget - made < 1) ? 1 : budget - made;
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            pending_cmds.push_back(rand_edit());
            made++;
          end else if ($urandom_range(0, 59) == 0) begin
            pending_cmds.push_back(rand_with(FN_SHOW));
            made++;
          end
          pending_cmds.push_back(rand_with(FN_TICK));
          made++;
        end
      end else begin
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          c = rand_raw();
          pending_cmds.push_back(c);
          if (c.func != FN_UNUSED) made++;
        end
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_cmds.push_back(make_cmd(FN_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_FILL, 0, 0, 128, 8'h55, 8'hff, 8'h00));
    pending_cmds.push_back(make_cmd(FN_FILL, 1, 0, 1, 8'hff, 8'h00, 8'ha5));
    pending_cmds.push_back(make_cmd(FN_FILL, 2, 127, 0, 8'hff, 8'hff, 8'hff));
    pending_cmds.push_back(make_cmd(FN_FILL, 125, 127, 255, 8'h00, 8'h81, 8'h7e));
    pending_cmds.push_back(make_cmd(FN_BLANK, 0, 127, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_RESTORE, 0, 127, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_ROT_R, 0, 3, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_ROT_L, 0, 3, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_ROT_R, 5, 5, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_ROT_L, 10, 127, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_ROT_R, 9, 3, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_BLANK, 3, 2, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_RESTORE, 127, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_BLANK, 2, 2, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_RESTORE, 2, 2, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_UNUSED, 127, 127, 255, 255, 255, 255));
    pending_cmds.push_back(make_cmd(FN_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_SHOW, 0, 0, 0, 0, 0, 0));
    repeat (3) pending_cmds.push_back(make_cmd(FN_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_SHOW, 0, 0, 0, 0, 0, 0));
    repeat (2) pending_cmds.push_back(make_cmd(FN_TICK, 0, 0, 0, 0, 0, 0));

    run_phase(2, 5, 6, 4, 1, 250);
    run_phase(0, 0, 0, 0, 0, 150);
    run_phase(1, 255, 3, 1, 2, 200);
    run_phase(3, 1, 2, 10, 3, 250);
    run_phase(7, 3, 9, 2, 1, 200);
    run_phase(255, 255, 255, 65535, 128, 100);
    run_phase(1, 2, 2, 1, 200, 150);

    wait_idle();
    if (errors == 0 && expected_ticks.size() == 0) begin
      $display("tb_led_strip_frame_buffer_serializer passed");
    end else begin
      $display("tb_led_strip_frame_buffer_serializer failed");
    end
    $finish;
  end

endmodule
